>>> rtl/swmm_pkg.sv
// Shared constants, command/status bundles and state type for the sliding window statistics unit.
package swmm_pkg;

    localparam int WINDOW    = 100;
    localparam int LAT_W     = 20;
    localparam int HELD_W    = 7;
    localparam int SLOT_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W     = $clog2(WINDOW + 1);
    localparam int SUM_W     = LAT_W + CNT_W;
    localparam int DIVC_W    = $clog2(SUM_W + 1);
    localparam int S_TDATA_W = ((LAT_W + 7) / 8) * 8;
    localparam int M_BITS    = 3 * LAT_W + HELD_W;
    localparam int M_TDATA_W = ((M_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_WORK,
        ST_FINISH
    } swmm_state_t;

    typedef struct packed {
        logic capture;
        logic update;
        logic work;
        logic publish;
    } swmm_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic div_done;
        logic out_busy;
    } swmm_sts_t;

endpackage

>>> rtl/sliding_window_min_max_mean_unit.sv
// Top level of the sliding window latency min/max/mean unit.
//
//  channel | dir | tdata fields (low bit first)                        | tuser
//  s_      | in  | latency[19:0]                                       | -
//  m_      | out | mean[19:0] min[39:20] max[59:40] samples_held[66:60] | -
//
// One transfer in gives one transfer out. For each item the ring memory is read
// one entry per cycle for min/max over the samples held after it (up to 100 with a
// full window), while a 27-step restoring divider forms the mean. Synchronous
// reset empties the window; no clearing pass.
// A waiting result sits in the output register; the next input is taken while it
// stalls, and only the publish step waits for m_tready.
module sliding_window_min_max_mean_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [swmm_pkg::S_TDATA_W-1:0]   s_tdata,  // latency
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [swmm_pkg::M_TDATA_W-1:0]   m_tdata   // mean, min, max, samples_held
);
    import swmm_pkg::*;

    swmm_cmd_t         cmd;
    swmm_sts_t         sts;
    logic [LAT_W-1:0]  mean_latency, min_latency, max_latency;
    logic [HELD_W-1:0] samples_held;

    swmm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    swmm_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .s_latency    (s_tdata[LAT_W-1:0]),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .mean_latency (mean_latency),
        .min_latency  (min_latency),
        .max_latency  (max_latency),
        .samples_held (samples_held)
    );

    assign m_tdata = M_TDATA_W'({samples_held, max_latency, min_latency, mean_latency});

endmodule

>>> rtl/swmm_ctrl.sv
// Sequencing state machine: accept, ring update, scan and divide, publish.
module swmm_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  swmm_pkg::swmm_sts_t sts,
    output swmm_pkg::swmm_cmd_t cmd
);
    import swmm_pkg::*;

    swmm_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        s_tready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = ST_WORK;
            end
            ST_WORK: begin
                cmd.work = 1'b1;
                if (sts.scan_done && sts.div_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!sts.out_busy) begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> cmd.update)
        else $error("update did not follow capture");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.publish |-> $past(sts.scan_done) && $past(sts.div_done))
        else $error("publish before scan and divide finished");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.capture, cmd.update, cmd.work, cmd.publish}))
        else $error("more than one command active");

endmodule

>>> rtl/swmm_dp.sv
// Datapath: sample ring, running sum, min/max scan, restoring divider, result register.
module swmm_dp (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  swmm_pkg::swmm_cmd_t          cmd,
    output swmm_pkg::swmm_sts_t          sts,
    input  logic [swmm_pkg::LAT_W-1:0]   s_latency,
    input  logic                         m_tready,
    output logic                         m_tvalid,
    output logic [swmm_pkg::LAT_W-1:0]   mean_latency,
    output logic [swmm_pkg::LAT_W-1:0]   min_latency,
    output logic [swmm_pkg::LAT_W-1:0]   max_latency,
    output logic [swmm_pkg::HELD_W-1:0]  samples_held
);
    import swmm_pkg::*;

    logic [LAT_W-1:0]  ring [WINDOW];
    logic [LAT_W-1:0]  rd_data_reg;
    logic [SLOT_W-1:0] rd_addr;
    logic              rd_en;

    logic [LAT_W-1:0]  sample_reg;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;

    logic [CNT_W-1:0]  scan_idx_reg, scan_idx_next;
    logic              pend_reg, pend_next;
    logic [LAT_W-1:0]  lo_reg, lo_next, hi_reg, hi_next;

    logic [DIVC_W-1:0] div_cnt_reg, div_cnt_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [CNT_W:0]    rem_shift, rem_diff;

    logic              m_tvalid_reg, m_tvalid_next;
    logic [LAT_W-1:0]  mean_out_reg, min_out_reg, max_out_reg;
    logic [HELD_W-1:0] held_out_reg;

    logic              full;
    logic              scan_issue;

    assign full       = (fill_reg == CNT_W'(WINDOW));
    assign scan_issue = cmd.work && (scan_idx_reg != fill_reg);
    assign rd_en      = cmd.capture || scan_issue;
    assign rd_addr    = cmd.capture ? slot_reg : scan_idx_reg[SLOT_W-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            ring[slot_reg] <= sample_reg;
        end
        if (rd_en) begin
            rd_data_reg <= ring[rd_addr];
        end
    end

    assign rem_shift = {rem_reg, quo_reg[SUM_W-1]};
    assign rem_diff  = rem_shift - {1'b0, fill_reg};

    always_comb begin
        slot_next     = slot_reg;
        fill_next     = fill_reg;
        sum_next      = sum_reg;
        scan_idx_next = scan_idx_reg;
        pend_next     = pend_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        div_cnt_next  = div_cnt_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        if (cmd.update) begin
            if (full) begin
                sum_next = sum_reg - SUM_W'(rd_data_reg) + SUM_W'(sample_reg);
            end else begin
                sum_next  = sum_reg + SUM_W'(sample_reg);
                fill_next = fill_reg + 1'b1;
            end
            slot_next     = (slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;
            scan_idx_next = '0;
            pend_next     = 1'b0;
            lo_next       = sample_reg;
            hi_next       = sample_reg;
            div_cnt_next  = DIVC_W'(SUM_W);
            rem_next      = '0;
            quo_next      = sum_next;
        end

        if (cmd.work) begin
            pend_next = scan_issue;
            if (scan_issue) begin
                scan_idx_next = scan_idx_reg + 1'b1;
            end
            if (pend_reg) begin
                if (rd_data_reg < lo_reg) lo_next = rd_data_reg;
                if (rd_data_reg > hi_reg) hi_next = rd_data_reg;
            end
            if (div_cnt_reg != '0) begin
                div_cnt_next = div_cnt_reg - 1'b1;
                if (!rem_diff[CNT_W]) begin
                    rem_next = rem_diff[CNT_W-1:0];
                    quo_next = {quo_reg[SUM_W-2:0], 1'b1};
                end else begin
                    rem_next = rem_shift[CNT_W-1:0];
                    quo_next = {quo_reg[SUM_W-2:0], 1'b0};
                end
            end
        end

        if (cmd.publish) begin
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg     <= '0;
            fill_reg     <= '0;
            sum_reg      <= '0;
            scan_idx_reg <= '0;
            pend_reg     <= 1'b0;
            div_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
            mean_out_reg <= '0;
            min_out_reg  <= '0;
            max_out_reg  <= '0;
            held_out_reg <= '0;
        end else begin
            slot_reg     <= slot_next;
            fill_reg     <= fill_next;
            sum_reg      <= sum_next;
            scan_idx_reg <= scan_idx_next;
            pend_reg     <= pend_next;
            div_cnt_reg  <= div_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cmd.publish) begin
                mean_out_reg <= quo_reg[LAT_W-1:0];
                min_out_reg  <= lo_reg;
                max_out_reg  <= hi_reg;
                held_out_reg <= HELD_W'(fill_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            sample_reg <= s_latency;
        end
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign sts.scan_done = (scan_idx_reg == fill_reg) && !pend_reg;
    assign sts.div_done  = (div_cnt_reg == '0);
    assign sts.out_busy  = m_tvalid_reg && !m_tready;

    assign m_tvalid     = m_tvalid_reg;
    assign mean_latency = mean_out_reg;
    assign min_latency  = min_out_reg;
    assign max_latency  = max_out_reg;
    assign samples_held = held_out_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(WINDOW) && slot_reg < SLOT_W'(WINDOW - 1) + 1'b1 - 1'b0 + 0)
        else $error("fill count or write slot out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !full |-> SLOT_W'(fill_reg) == slot_reg)
        else $error("write slot out of step with fill count");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.publish |-> lo_reg <= hi_reg && lo_reg <= quo_reg[LAT_W-1:0]
                        && quo_reg <= SUM_W'(hi_reg))
        else $error("mean outside min/max range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.publish |-> fill_reg != '0)
        else $error("result published for empty window");

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for the sliding window latency min/max/mean unit.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import swmm_pkg::*;

    localparam logic [LAT_W-1:0] LAT_MAX = '1;
    localparam int RAND_ITEMS = 434;
    localparam int PHASE_LEN  = 160;

    typedef enum logic [1:0] {
        PH_RX_SLOW,
        PH_TX_SLOW,
        PH_FREE
    } traffic_phase_t;

    typedef struct packed {
        traffic_phase_t   phase;
        logic [LAT_W-1:0] lat;
    } lat_item_t;

    typedef struct packed {
        logic [LAT_W-1:0]  mean_lat;
        logic [LAT_W-1:0]  lo_lat;
        logic [LAT_W-1:0]  hi_lat;
        logic [HELD_W-1:0] held;
    } win_stats_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    lat_item_t      lat_backlog[$];
    win_stats_t     stats_due[$];
    int             queued   = 0;
    int             err_cnt  = 0;
    bit             tx_busy  = 1'b0;
    traffic_phase_t rx_phase = PH_RX_SLOW;

    // window shadow
    logic [LAT_W-1:0] ring[WINDOW];
    int               ring_slot = 0;
    int               ring_fill = 0;
    logic [SUM_W-1:0] ring_sum  = '0;

    sliding_window_min_max_mean_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic int idle_pct(input bit rx_side, input traffic_phase_t ph);
        case (ph)
            PH_RX_SLOW: return rx_side ? 58 : 19;
            PH_TX_SLOW: return rx_side ? 19 : 58;
            default:    return 0;
        endcase
    endfunction

    task automatic push_sample(input logic [LAT_W-1:0] lat);
        win_stats_t       s;
        logic [LAT_W-1:0] lo;
        logic [LAT_W-1:0] hi;
        if (ring_fill >= WINDOW) begin
            ring_sum -= SUM_W'(ring[ring_slot]);
        end else begin
            ring_fill++;
        end
        ring[ring_slot] = lat;
        ring_sum += SUM_W'(lat);
        ring_slot = (ring_slot + 1 == WINDOW) ? 0 : ring_slot + 1;
        lo = lat;
        hi = lat;
        for (int i = 0; i < ring_fill; i++) begin
            if (ring[i] < lo) lo = ring[i];
            if (ring[i] > hi) hi = ring[i];
        end
        s.mean_lat = LAT_W'(ring_sum / SUM_W'(ring_fill));
        s.lo_lat   = lo;
        s.hi_lat   = hi;
        s.held     = HELD_W'(ring_fill);
        stats_due.push_back(s);
    endtask

    function automatic void cmp_field(input string name, input logic [LAT_W-1:0] want,
                                      input logic [LAT_W-1:0] got);
        if (want !== got) begin
            $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            err_cnt++;
        end
    endfunction

    task automatic add_item(input logic [LAT_W-1:0] v);
        lat_item_t it;
        it.lat   = v;
        it.phase = (queued < PHASE_LEN) ? PH_RX_SLOW :
                   (queued < 2 * PHASE_LEN) ? PH_TX_SLOW : PH_FREE;
        lat_backlog.push_back(it);
        queued++;
    endtask

    // accept side: predict on input transfer, check on output transfer
    always @(posedge aclk) begin
        win_stats_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                push_sample(s_tdata[LAT_W-1:0]);
                rx_phase = lat_backlog[0].phase;
                void'(lat_backlog.pop_front());
                tx_busy = 1'b0;
            end
            if (m_tvalid && m_tready) begin
                if (stats_due.size() == 0) begin
                    $display("%0t unexpected transfer: expected none, actual %h",
                             $time, m_tdata);
                    err_cnt++;
                end else begin
                    want = stats_due.pop_front();
                    cmp_field("mean", want.mean_lat, m_tdata[LAT_W-1:0]);
                    cmp_field("min", want.lo_lat, m_tdata[2*LAT_W-1:LAT_W]);
                    cmp_field("max", want.hi_lat, m_tdata[3*LAT_W-1:2*LAT_W]);
                    cmp_field("samples_held", LAT_W'(want.held),
                              LAT_W'(m_tdata[3*LAT_W+HELD_W-1:3*LAT_W]));
                end
            end
        end
    end

    // drive side
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            if (!tx_busy) begin
                if (lat_backlog.size() > 0 &&
                    $urandom_range(99) >= idle_pct(1'b0, lat_backlog[0].phase)) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= S_TDATA_W'(lat_backlog[0].lat);
                    tx_busy = 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(99) >= idle_pct(1'b1, rx_phase));
        end
    end

    initial begin
        int               n;
        int               mode;
        int               run;
        logic [LAT_W-1:0] v;
        logic [LAT_W-1:0] run_val;

        // directed: extremes, first sample alone, bit patterns
        add_item('0);
        add_item(LAT_MAX);
        add_item('0);
        add_item(LAT_W'(1));
        add_item(LAT_MAX - 1);
        add_item(20'h55555);
        add_item(20'hAAAAA);
        add_item(20'h80000);
        add_item(20'h7FFFF);
        add_item(20'h00010);
        add_item(20'hFFFEF);
        add_item(LAT_MAX);
        add_item(LAT_MAX);
        add_item(LAT_W'(2));
        add_item(20'h12345);
        add_item(20'hEDCBA);

        // random: segments of a chosen flavor; long constant runs fill the window
        n = 0;
        while (n < RAND_ITEMS) begin
            mode    = $urandom_range(0, 7);
            run     = (mode == 7) ? $urandom_range(100, 110) : $urandom_range(1, 30);
            run_val = $urandom_range(1) ? LAT_MAX : '0;
            for (int k = 0; k < run && n < RAND_ITEMS; k++) begin
                case (mode)
                    0, 1:    v = LAT_W'($urandom);
                    2:       v = LAT_W'($urandom_range(0, 31));
                    3:       v = LAT_MAX - LAT_W'($urandom_range(0, 31));
                    4:       v = LAT_W'(1) << $urandom_range(0, LAT_W - 1);
                    5:       v = ~(LAT_W'(1) << $urandom_range(0, LAT_W - 1));
                    6:       v = $urandom_range(1) ? LAT_MAX : '0;
                    default: v = run_val;
                endcase
                add_item(v);
                n++;
            end
        end

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (lat_backlog.size() != 0 || stats_due.size() != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("[sliding_window_min_max_mean_unit] OK");
        end else begin
            $display("[sliding_window_min_max_mean_unit] ERROR");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("[sliding_window_min_max_mean_unit] ERROR");
        $finish;
    end

endmodule

>>> sliding_window_min_max_mean_unit.f
rtl/swmm_pkg.sv
rtl/swmm_ctrl.sv
rtl/swmm_dp.sv
rtl/sliding_window_min_max_mean_unit.sv
verif/tb_top.sv
